// ===== rtl/core/bezier_surface_point_eval_defines.svh =====
// ----------------------------------------------------------------------------
// Bezier surface evaluator assertion macros
// Shared concurrent assertion forms for the surface evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef BEZIER_SURFACE_POINT_EVAL_DEFINES_SVH
`define BEZIER_SURFACE_POINT_EVAL_DEFINES_SVH

// same-cycle implication
`define BSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier surface evaluator package
// Sizes, binomial table and shared types.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int MAX_SIDE   = 8;
    localparam int GRID_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W      = $clog2(MAX_SIDE);
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int Q15_W      = 16;
    localparam logic [Q15_W-1:0] Q15_ONE = 16'd32768;

    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_EVAL  = 1'b1;

    typedef logic [MAX_SIDE-1:0][Q15_W-1:0] t_basis_tab;

    typedef struct packed {
        logic               done;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_acc_res;

    localparam logic [5:0] BINOM [MAX_SIDE][MAX_SIDE] = '{
        '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

endpackage

// ===== rtl/core/bsp_chan_if.sv =====
// ----------------------------------------------------------------------------
// Bezier surface evaluator channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface bsp_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [5:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        s_param;
    logic [15:0]        t_param;

    modport source (output valid, opcode, point_index, coord_x, coord_y, coord_z,
                    s_param, t_param, input ready);
    modport sink   (input valid, opcode, point_index, coord_x, coord_y, coord_z,
                    s_param, t_param, output ready);
endinterface

interface bsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface bsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] points_per_side;

    modport source (output valid, points_per_side, input ready);
    modport sink   (input valid, points_per_side, output ready);
endinterface

// ===== rtl/core/bsp_basis.sv =====
// ----------------------------------------------------------------------------
// Bernstein basis builder
// Builds row and column basis tables with one multiply step per cycle.
// ----------------------------------------------------------------------------
module bsp_basis (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bsp_pkg::IDX_W-1:0]     i_deg,
    input  logic [bsp_pkg::Q15_W-1:0]     i_s,
    input  logic [bsp_pkg::Q15_W-1:0]     i_t,
    output logic                          o_done,
    output bsp_pkg::t_basis_tab           o_row,
    output bsp_pkg::t_basis_tab           o_col
);

    logic                        r_busy, n_busy;
    logic                        r_done;
    logic [bsp_pkg::IDX_W-1:0]   r_i, r_k, r_d;
    logic [bsp_pkg::Q15_W-1:0]   r_s, r_t, r_us, r_ut, r_ps, r_pt;
    bsp_pkg::t_basis_tab         r_row, r_col;

    logic [bsp_pkg::Q15_W-1:0]   fs, ft;
    logic [31:0]                 ms, mt;
    logic [21:0]                 cs, ct;
    logic [bsp_pkg::Q15_W-1:0]   sat_s, sat_t;

    always_comb begin
        fs    = (r_k < r_i) ? r_s : r_us;
        ft    = (r_k < r_i) ? r_t : r_ut;
        ms    = 32'(r_ps) * 32'(fs) + 32'd16384;
        mt    = 32'(r_pt) * 32'(ft) + 32'd16384;
        cs    = 22'(r_ps) * 22'(bsp_pkg::BINOM[r_d][r_i]);
        ct    = 22'(r_pt) * 22'(bsp_pkg::BINOM[r_d][r_i]);
        sat_s = (cs > 22'(bsp_pkg::Q15_ONE)) ? bsp_pkg::Q15_ONE : cs[15:0];
        sat_t = (ct > 22'(bsp_pkg::Q15_ONE)) ? bsp_pkg::Q15_ONE : ct[15:0];
        n_busy = r_busy && !((r_k == r_d) && (r_i == r_d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !n_busy;
            r_busy <= i_start ? 1'b1 : n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d  <= i_deg;
            r_s  <= i_s;
            r_t  <= i_t;
            r_us <= bsp_pkg::Q15_ONE - i_s;
            r_ut <= bsp_pkg::Q15_ONE - i_t;
            r_i  <= '0;
            r_k  <= '0;
            r_ps <= bsp_pkg::Q15_ONE;
            r_pt <= bsp_pkg::Q15_ONE;
        end else if (r_busy) begin
            if (r_k != r_d) begin
                r_ps <= ms[30:15];
                r_pt <= mt[30:15];
                r_k  <= r_k + 1'b1;
            end else begin
                r_row[r_i] <= sat_s;
                r_col[r_i] <= sat_t;
                r_ps <= bsp_pkg::Q15_ONE;
                r_pt <= bsp_pkg::Q15_ONE;
                r_k  <= '0;
                r_i  <= r_i + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_row  = r_row;
    assign o_col  = r_col;

endmodule

// ===== rtl/core/bsp_accum.sv =====
// ----------------------------------------------------------------------------
// Control grid store and accumulator
// Holds the control grid and sums weighted points in a three-stage pipe.
// ----------------------------------------------------------------------------
module bsp_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [bsp_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic [95:0]                   i_wr_data,
    input  logic                          i_start,
    input  logic [bsp_pkg::IDX_W-1:0]     i_deg,
    input  bsp_pkg::t_basis_tab           i_row,
    input  bsp_pkg::t_basis_tab           i_col,
    output bsp_pkg::t_acc_res             o_res
);

    logic [95:0] mem [bsp_pkg::GRID_CELLS];

    logic                        r_issue, r_v1, r_v2, r_done;
    logic [bsp_pkg::IDX_W-1:0]   r_i, r_j, r_d;
    logic [bsp_pkg::ADDR_W-1:0]  r_base;
    logic [95:0]                 r_rd;
    logic [30:0]                 r_w;
    logic signed [63:0]          r_prod [3];
    logic signed [63:0]          r_sum  [3];
    logic [bsp_pkg::ADDR_W-1:0]  rd_addr;
    logic                        last;

    assign rd_addr = r_base + bsp_pkg::ADDR_W'(r_j);
    assign last    = (r_i == r_d) && (r_j == r_d);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_issue <= i_start ? 1'b1 : (r_issue && !last);
            r_v1    <= r_issue;
            r_v2    <= r_v1;
            r_done  <= r_v2 && !r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d    <= i_deg;
            r_i    <= '0;
            r_j    <= '0;
            r_base <= '0;
        end else if (r_issue) begin
            if (r_j == r_d) begin
                r_j    <= '0;
                r_i    <= r_i + 1'b1;
                r_base <= r_base + bsp_pkg::ADDR_W'(r_d) + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        r_w <= 31'(32'(i_row[r_i]) * 32'(i_col[r_j]));
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= 64'(signed'(r_rd[32*c +: 32])) * signed'({33'd0, r_w});
            if (i_start) begin
                r_sum[c] <= '0;
            end else if (r_v2) begin
                r_sum[c] <= r_sum[c] + (r_prod[c] >>> 15);
            end
        end
    end

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (r < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    always_comb begin
        o_res.done = r_done;
        o_res.x    = round_sat(r_sum[0]);
        o_res.y    = round_sat(r_sum[1]);
        o_res.z    = round_sat(r_sum[2]);
    end

endmodule

// ===== rtl/core/bezier_surface_point_eval.sv =====
// ----------------------------------------------------------------------------
// Bezier surface point evaluator
// Stores a control grid and evaluates tensor-product Bezier surface points.
// ----------------------------------------------------------------------------
// channel  dir  payload
// i_in     in   opcode, point_index, coord_x/y/z, s_param, t_param
// o_out    out  point_x, point_y, point_z
// i_cfg    in   points_per_side
//
// Write transfer: no result.
// Evaluate transfer: the basis builder makes the row and column tables one
// multiply step at a time, then the grid memory port and accumulator sum the
// weighted control points.
// Reset: synchronous, no clearing pass; points_per_side returns to 4.
// A result waiting on o_out does not block the next transfer on i_in.
// ----------------------------------------------------------------------------
`include "bezier_surface_point_eval_defines.svh"

module bezier_surface_point_eval (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsp_in_if.sink    i_in,
    bsp_out_if.source o_out,
    bsp_cfg_if.sink   i_cfg
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BASIS = 2'd1;
    localparam logic [1:0] S_ACC   = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [3:0]                  r_pps;
    logic                        r_out_valid;
    logic signed [31:0]          r_px, r_py, r_pz;
    logic [bsp_pkg::IDX_W-1:0]   r_deg;
    logic [bsp_pkg::Q15_W-1:0]   r_s, r_t;
    logic                        r_bstart, r_astart;

    logic                        in_xfer, eval_go, basis_done, out_free;
    logic [3:0]                  n_clamp;
    bsp_pkg::t_basis_tab         row_tab, col_tab;
    bsp_pkg::t_acc_res           acc_res;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign eval_go     = in_xfer && (i_in.opcode == bsp_pkg::OP_EVAL);
    assign out_free    = !r_out_valid || o_out.ready;
    assign n_clamp     = (r_pps < 4'd2) ? 4'd2 :
                         (r_pps > 4'(bsp_pkg::MAX_SIDE)) ? 4'(bsp_pkg::MAX_SIDE) : r_pps;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (eval_go) n_state = S_BASIS;
            S_BASIS: if (basis_done) n_state = S_ACC;
            S_ACC:   if (acc_res.done) n_state = S_LOAD;
            S_LOAD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pps       <= 4'd4;
            r_out_valid <= 1'b0;
            r_bstart    <= 1'b0;
            r_astart    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bstart <= eval_go;
            r_astart <= (r_state == S_BASIS) && basis_done;
            if (i_cfg.valid && i_cfg.ready) begin
                r_pps <= i_cfg.points_per_side;
            end
            if ((r_state == S_LOAD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_deg <= bsp_pkg::IDX_W'(n_clamp - 4'd1);
            r_s   <= (i_in.s_param > bsp_pkg::Q15_ONE) ? bsp_pkg::Q15_ONE : i_in.s_param;
            r_t   <= (i_in.t_param > bsp_pkg::Q15_ONE) ? bsp_pkg::Q15_ONE : i_in.t_param;
        end
        if ((r_state == S_LOAD) && out_free) begin
            r_px <= acc_res.x;
            r_py <= acc_res.y;
            r_pz <= acc_res.z;
        end
    end

    bsp_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_bstart),
        .i_deg   (r_deg),
        .i_s     (r_s),
        .i_t     (r_t),
        .o_done  (basis_done),
        .o_row   (row_tab),
        .o_col   (col_tab)
    );

    bsp_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (in_xfer && (i_in.opcode == bsp_pkg::OP_WRITE)),
        .i_wr_addr (i_in.point_index),
        .i_wr_data ({i_in.coord_z, i_in.coord_y, i_in.coord_x}),
        .i_start   (r_astart),
        .i_deg     (r_deg),
        .i_row     (row_tab),
        .i_col     (col_tab),
        .o_res     (acc_res)
    );

    assign o_out.valid   = r_out_valid;
    assign o_out.point_x = r_px;
    assign o_out.point_y = r_py;
    assign o_out.point_z = r_pz;

    `BSP_ASSERT_NOW(a_basis_done_state, basis_done, r_state == S_BASIS, "basis done early")
    `BSP_ASSERT_NOW(a_acc_done_state, acc_res.done, r_state == S_ACC, "acc done early")
    `BSP_ASSERT_NEXT(a_load_shows, (r_state == S_LOAD) && out_free, o_out.valid, "result lost")

endmodule

// ===== tb/bsp_tb_chk.sv =====
// ----------------------------------------------------------------------------
// Bezier surface evaluator checker
// Watches the item, result and configuration channels, predicts each surface
// point from its own copy of the control grid and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bsp_tb_chk (
    input  logic i_clk,
    input  logic i_rst_n,
    bsp_in_if    i_in,
    bsp_out_if   i_out,
    bsp_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    logic [3:0] side_reg;
    longint     grid [bsp_pkg::GRID_CELLS][3];
    t_point     exp_points [$];

    initial o_errors = 0;
    assign o_pending = exp_points.size();

    function automatic longint unsigned choose(int unsigned d, int unsigned i);
        longint unsigned c;
        c = 1;
        for (int unsigned k = 0; k < i; k++) c = c * (d - k) / (k + 1);
        return c;
    endfunction

    function automatic bsp_pkg::t_basis_tab bernstein(int unsigned d, longint unsigned x);
        bsp_pkg::t_basis_tab tab;
        longint unsigned     u, p;
        tab = '0;
        u = 32768 - x;
        for (int unsigned i = 0; i <= d; i++) begin
            p = 32768;
            for (int unsigned k = 0; k < i; k++) p = (p * x + 16384) >> 15;
            for (int unsigned k = 0; k < d - i; k++) p = (p * u + 16384) >> 15;
            p = p * choose(d, i);
            if (p > 32768) p = 32768;
            tab[i] = p[15:0];
        end
        return tab;
    endfunction

    function automatic t_point surface_point(logic [15:0] s_in, logic [15:0] t_in);
        int unsigned         n;
        longint unsigned     s, t, w;
        bsp_pkg::t_basis_tab rows, cols;
        longint              acc [3];
        longint              v;
        logic signed [31:0]  res [3];
        t_point              pt;
        n = side_reg;
        if (n < 2) n = 2;
        if (n > bsp_pkg::MAX_SIDE) n = bsp_pkg::MAX_SIDE;
        s = (s_in > 32768) ? 32768 : s_in;
        t = (t_in > 32768) ? 32768 : t_in;
        rows = bernstein(n - 1, s);
        cols = bernstein(n - 1, t);
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned j = 0; j < n; j++) begin
                w = longint'(rows[i]) * longint'(cols[j]);
                for (int c = 0; c < 3; c++)
                    acc[c] += (grid[i * n + j][c] * longint'(w)) >>> 15;
            end
        end
        for (int c = 0; c < 3; c++) begin
            v = (acc[c] + 16384) >>> 15;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res[c] = v[31:0];
        end
        pt.x = res[0];
        pt.y = res[1];
        pt.z = res[2];
        return pt;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch %s: got %h expected %h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_reg <= 4'd4;
            exp_points.delete();
            for (int k = 0; k < bsp_pkg::GRID_CELLS; k++)
                for (int c = 0; c < 3; c++) grid[k][c] = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) side_reg <= i_cfg.points_per_side;
            if (i_in.valid && i_in.ready) begin
                if (i_in.opcode == bsp_pkg::OP_WRITE) begin
                    grid[i_in.point_index][0] = i_in.coord_x;
                    grid[i_in.point_index][1] = i_in.coord_y;
                    grid[i_in.point_index][2] = i_in.coord_z;
                end else begin
                    exp_points = {exp_points, surface_point(i_in.s_param, i_in.t_param)};
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (exp_points.size() == 0) begin
                    report("unexpected result", i_out.point_x, 'x);
                end else begin
                    t_point e;
                    e = exp_points.pop_front();
                    if (i_out.point_x !== e.x) report("point_x", i_out.point_x, e.x);
                    if (i_out.point_y !== e.y) report("point_y", i_out.point_y, e.y);
                    if (i_out.point_z !== e.z) report("point_z", i_out.point_z, e.z);
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bezier surface evaluator testbench
// Fills the control grid, evaluates directed corner parameters, then random
// write/evaluate traffic over several grid sizes and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam logic [3:0] SIDES [10] = '{4'd2, 4'd8, 4'd0, 4'd1, 4'd15, 4'd4, 4'd5,
                                          4'd3, 4'd7, 4'd6};

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   tx_idle, rx_idle;
    int   hold_left = 0;
    logic hold_start;

    bsp_in_if  in_ch();
    bsp_out_if out_ch();
    bsp_cfg_if cfg_ch();

    bezier_surface_point_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    bsp_tb_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_start) hold_left <= 600;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_left != 0) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic send(logic op, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, logic [15:0] s, logic [15:0] t);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.point_index <= idx;
        in_ch.coord_x     <= x;
        in_ch.coord_y     <= y;
        in_ch.coord_z     <= z;
        in_ch.s_param     <= s;
        in_ch.t_param     <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_side(logic [3:0] n);
        drain();
        repeat (200) @(posedge i_clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.points_per_side <= n;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_param();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return bsp_pkg::Q15_ONE;
            2: return 16'($urandom_range(65535, 32769));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    task automatic fill_grid(int mode);
        logic [31:0] v;
        for (int k = 0; k < bsp_pkg::GRID_CELLS; k++) begin
            v = (mode == 0) ? 32'h7FFF_FFFF : (mode == 1) ? 32'h8000_0000 : rand_coord();
            send(bsp_pkg::OP_WRITE, k[5:0], v, (mode == 2) ? rand_coord() : ~v,
                 (mode == 2) ? rand_coord() : v, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic eval(logic [15:0] s, logic [15:0] t);
        send(bsp_pkg::OP_EVAL, 6'($urandom), $urandom, $urandom, $urandom, s, t);
    endtask

    task automatic random_items(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 35)
                send(bsp_pkg::OP_WRITE, 6'($urandom_range(63)), rand_coord(), rand_coord(),
                     rand_coord(), 16'($urandom), 16'($urandom));
            else
                eval(rand_param(), rand_param());
        end
    endtask

    initial begin
        in_ch.valid            <= 1'b0;
        in_ch.opcode           <= bsp_pkg::OP_WRITE;
        in_ch.point_index      <= '0;
        in_ch.coord_x          <= '0;
        in_ch.coord_y          <= '0;
        in_ch.coord_z          <= '0;
        in_ch.s_param          <= '0;
        in_ch.t_param          <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.points_per_side <= 4'd4;
        hold_start             <= 1'b0;
        tx_idle                = 24;
        rx_idle                = 55;
        i_rst_n                <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturating and random grids, then corner and mid parameters
        fill_grid(0);
        eval(16'd0, 16'd0);
        eval(bsp_pkg::Q15_ONE, bsp_pkg::Q15_ONE);
        eval(16'd16384, 16'd16384);
        fill_grid(1);
        eval(16'd0, bsp_pkg::Q15_ONE);
        eval(16'd16384, 16'd16384);
        fill_grid(2);
        eval(16'hFFFF, 16'hFFFF);
        eval(16'd1, 16'd32767);
        eval(bsp_pkg::Q15_ONE, 16'd0);
        eval(16'd12345, 16'd20000);

        for (int k = 0; k < 10; k++) begin
            if (k == 4) begin
                tx_idle = 55;
                rx_idle = 24;
            end
            if (k == 7) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            set_side(SIDES[k]);
            if (k == 5) begin
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            random_items(20);
        end
        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
